[design/bounded_deque_with_aggregates_core_macros.svh]
// ---------------------------------------------------------------------------
// Bounded deque assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_AGGREGATES_CORE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_AGGREGATES_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BDQA_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);
`define BDQA_ASSERT(label, prop, msg) `BDQA_ASSERT_CLK(label, clk, rst_n, prop, msg)
`else
`define BDQA_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg)
`define BDQA_ASSERT(label, prop, msg)
`endif

`endif

[design/bdqa_pkg.sv]
// ---------------------------------------------------------------------------
// Bounded deque package
// Field widths, opcodes, status codes, cell modes and aggregate bundle.
// ---------------------------------------------------------------------------
package bdqa_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int TOTAL_W  = 36;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_STATUS     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_SHIFT_UP,
    CM_SHIFT_DOWN,
    CM_FILL_BACK,
    CM_DROP_BACK,
    CM_ROTATE
  } cell_mode_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic signed [VALUE_W-1:0] largest;
    logic signed [VALUE_W-1:0] smallest_even;
  } agg_t;

endpackage

[design/bdqa_if.sv]
// ---------------------------------------------------------------------------
// Bounded deque channels
// Valid/ready interfaces for the operation and result transactions.
// ---------------------------------------------------------------------------
interface bdqa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [bdqa_pkg::OP_W-1:0]     op;
  logic signed [bdqa_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdqa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bdqa_pkg::VALUE_W-1:0]  popped_value;
  logic        [bdqa_pkg::STATUS_W-1:0] status;
  logic        [bdqa_pkg::COUNT_W-1:0]  entry_count;
  logic signed [bdqa_pkg::TOTAL_W-1:0]  total;
  logic signed [bdqa_pkg::VALUE_W-1:0]  largest;
  logic signed [bdqa_pkg::VALUE_W-1:0]  smallest_even;
  logic                                 is_empty;

  modport source (output valid, output popped_value, output status, output entry_count,
                  output total, output largest, output smallest_even, output is_empty,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input entry_count,
                  input total, input largest, input smallest_even, input is_empty,
                  output ready);
endinterface

[design/bdqa_cell.sv]
// ---------------------------------------------------------------------------
// Bounded deque cell
// One storage slot with an occupied bit; shifts, fills or drops per mode.
// ---------------------------------------------------------------------------
module bdqa_cell #(
  parameter int DATA_WIDTH = bdqa_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bdqa_pkg::cell_mode_t   mode,
  input  logic [DATA_WIDTH-1:0]  push_value,
  input  logic [DATA_WIDTH-1:0]  lo_data,
  input  logic                   lo_valid,
  input  logic [DATA_WIDTH-1:0]  hi_data,
  input  logic                   hi_valid,
  output logic [DATA_WIDTH-1:0]  data_r,
  output logic                   valid_r
);

  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (mode)
      bdqa_pkg::CM_SHIFT_UP: begin
        data_nxt  = lo_data;
        valid_nxt = lo_valid;
      end
      bdqa_pkg::CM_SHIFT_DOWN, bdqa_pkg::CM_ROTATE: begin
        data_nxt  = hi_data;
        valid_nxt = hi_valid;
      end
      bdqa_pkg::CM_FILL_BACK: begin
        // take the value in the first free slot
        if (!valid_r && lo_valid) begin
          data_nxt  = push_value;
          valid_nxt = 1'b1;
        end
      end
      bdqa_pkg::CM_DROP_BACK: begin
        // release the last occupied slot
        if (valid_r && !hi_valid) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
        data_nxt  = data_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

endmodule

[design/bdqa_accum.sv]
// ---------------------------------------------------------------------------
// Bounded deque aggregate accumulator
// Folds one slot per cycle, while enabled, into sum, maximum and least even value.
// ---------------------------------------------------------------------------
module bdqa_accum (
  input  logic                                 clk,
  input  logic                                 clear,
  input  logic                                 en,
  input  logic signed [bdqa_pkg::VALUE_W-1:0]  data,
  input  logic                                 data_valid,
  output bdqa_pkg::agg_t                       agg
);

  logic signed [bdqa_pkg::TOTAL_W-1:0] sum_r, sum_nxt;
  logic signed [bdqa_pkg::VALUE_W-1:0] max_r, max_nxt;
  logic signed [bdqa_pkg::VALUE_W-1:0] min_r, min_nxt;
  logic                                have_any_r, have_any_nxt;
  logic                                have_even_r, have_even_nxt;

  always_comb begin
    sum_nxt       = sum_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    have_any_nxt  = have_any_r;
    have_even_nxt = have_even_r;
    if (clear) begin
      sum_nxt       = '0;
      have_any_nxt  = 1'b0;
      have_even_nxt = 1'b0;
    end else if (en && data_valid) begin
      sum_nxt = sum_r + bdqa_pkg::TOTAL_W'(data);
      if (!have_any_r || data > max_r) begin
        max_nxt = data;
      end
      have_any_nxt = 1'b1;
      if (!data[0] && (!have_even_r || data < min_r)) begin
        min_nxt       = data;
        have_even_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r       <= sum_nxt;
    max_r       <= max_nxt;
    min_r       <= min_nxt;
    have_any_r  <= have_any_nxt;
    have_even_r <= have_even_nxt;
  end

  always_comb begin
    agg.total         = sum_r;
    agg.largest       = have_any_r  ? max_r : '0;
    agg.smallest_even = have_even_r ? min_r : '1;
  end

endmodule

[design/bounded_deque_with_aggregates_core.sv]
// ---------------------------------------------------------------------------
// Bounded deque with aggregates
// Double-ended queue held in a chain of slot cells, with sum, maximum and
// least even value reported after every operation.
//
//   channel | dir | transaction
//   in_ch   | in  | op, value
//   out_ch  | out | popped_value, status, entry_count, total, largest,
//           |     | smallest_even, is_empty
//
// An operation is applied to the cells at the accept edge; the chain then
// rotates once around while the accumulator folds in the front slot, and
// the result is then loaded into the output registers.
// A new operation is accepted while a result still waits on out_ch.
// Reset empties the store at once; slot data is never cleared.
// ---------------------------------------------------------------------------
`include "bounded_deque_with_aggregates_core_macros.svh"

module bounded_deque_with_aggregates_core #(
  parameter int DEPTH      = bdqa_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = bdqa_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  bdqa_in_if.sink           in_ch,
  bdqa_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                             state_r;
  logic [CNT_W-1:0]                   occ_r;
  logic [CNT_W-1:0]                   occ_nxt;
  logic [IDX_W-1:0]                   step_r;
  logic [bdqa_pkg::STATUS_W-1:0]      status_r;
  logic [bdqa_pkg::STATUS_W-1:0]      status_nxt;
  logic [DATA_WIDTH-1:0]              popped_r;
  logic                               pop_back_r;
  logic                               out_valid_r;
  logic signed [bdqa_pkg::VALUE_W-1:0] out_popped_r;
  logic [bdqa_pkg::STATUS_W-1:0]      out_status_r;
  logic [bdqa_pkg::COUNT_W-1:0]       out_count_r;
  bdqa_pkg::agg_t                     out_agg_r;
  logic                               out_empty_r;

  logic                               in_acc;
  logic                               out_load;
  logic                               full;
  logic                               empty;
  logic                               pop_front_ok;
  logic                               pop_back_ok;
  logic                               occ_cells_ok;
  logic                               push_ok;
  bdqa_pkg::cell_mode_t               mode;
  logic [DATA_WIDTH-1:0]              push_value;

  logic [DATA_WIDTH-1:0]              cell_data [DEPTH];
  logic [DEPTH-1:0]                   cell_valid;
  logic [DATA_WIDTH-1:0]              lo_data   [DEPTH];
  logic [DEPTH-1:0]                   lo_valid;
  logic [DATA_WIDTH-1:0]              hi_data   [DEPTH];
  logic [DEPTH-1:0]                   hi_valid;

  bdqa_pkg::agg_t                     agg;
  logic signed [bdqa_pkg::VALUE_W-1:0] front_ext;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign full        = (occ_r == CNT_W'(DEPTH));
  assign empty       = (occ_r == '0);
  assign push_value  = in_ch.value[DATA_WIDTH-1:0];
  assign front_ext   = bdqa_pkg::VALUE_W'($signed(cell_data[0]));

  assign occ_cells_ok = ((occ_r == '0) == !cell_valid[0]) && (full == cell_valid[DEPTH-1]);
  assign push_ok      = in_acc && !full && ((in_ch.op == bdqa_pkg::OP_PUSH_FRONT) ||
                                            (in_ch.op == bdqa_pkg::OP_PUSH_BACK));

  always_comb begin
    mode         = bdqa_pkg::CM_HOLD;
    status_nxt   = bdqa_pkg::ST_OK;
    occ_nxt      = occ_r;
    pop_front_ok = 1'b0;
    pop_back_ok  = 1'b0;
    if (state_r == S_SCAN) begin
      mode = bdqa_pkg::CM_ROTATE;
    end else if (in_acc) begin
      case (in_ch.op)
        bdqa_pkg::OP_PUSH_FRONT, bdqa_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = bdqa_pkg::ST_FULL;
          end else begin
            mode    = (in_ch.op == bdqa_pkg::OP_PUSH_FRONT) ? bdqa_pkg::CM_SHIFT_UP
                                                            : bdqa_pkg::CM_FILL_BACK;
            occ_nxt = occ_r + CNT_W'(1);
          end
        end
        bdqa_pkg::OP_POP_FRONT, bdqa_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_nxt = bdqa_pkg::ST_EMPTY;
          end else begin
            pop_front_ok = (in_ch.op == bdqa_pkg::OP_POP_FRONT);
            pop_back_ok  = (in_ch.op == bdqa_pkg::OP_POP_BACK);
            mode         = pop_front_ok ? bdqa_pkg::CM_SHIFT_DOWN : bdqa_pkg::CM_DROP_BACK;
            occ_nxt      = occ_r - CNT_W'(1);
          end
        end
        default: begin
          mode = bdqa_pkg::CM_HOLD;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_lo_edge
      assign lo_data[i]  = push_value;
      assign lo_valid[i] = 1'b1;
    end else begin : g_lo_link
      assign lo_data[i]  = cell_data[i-1];
      assign lo_valid[i] = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_edge
      // wrap the front slot around while rotating
      assign hi_data[i]  = cell_data[0];
      assign hi_valid[i] = (mode == bdqa_pkg::CM_ROTATE) ? cell_valid[0] : 1'b0;
    end else begin : g_hi_link
      assign hi_data[i]  = cell_data[i+1];
      assign hi_valid[i] = cell_valid[i+1];
    end

    bdqa_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .mode       (mode),
      .push_value (push_value),
      .lo_data    (lo_data[i]),
      .lo_valid   (lo_valid[i]),
      .hi_data    (hi_data[i]),
      .hi_valid   (hi_valid[i]),
      .data_r     (cell_data[i]),
      .valid_r    (cell_valid[i])
    );
  end

  bdqa_accum u_accum (
    .clk        (clk),
    .clear      (in_acc),
    .en         (state_r == S_SCAN),
    .data       (front_ext),
    .data_valid (cell_valid[0]),
    .agg        (agg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      step_r      <= '0;
      pop_back_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r    <= S_SCAN;
            step_r     <= '0;
            occ_r      <= occ_nxt;
            status_r   <= status_nxt;
            popped_r   <= pop_front_ok ? cell_data[0] : '0;
            pop_back_r <= pop_back_ok;
          end
        end
        S_SCAN: begin
          // the dropped back slot passes the front at the new occupancy
          if (pop_back_r && (CNT_W'(step_r) == occ_r)) begin
            popped_r <= cell_data[0];
          end
          step_r <= step_r + IDX_W'(1);
          if (step_r == IDX_W'(DEPTH - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_popped_r <= bdqa_pkg::VALUE_W'($signed(popped_r));
            out_status_r <= status_r;
            out_count_r  <= bdqa_pkg::COUNT_W'(occ_r);
            out_agg_r    <= agg;
            out_empty_r  <= (occ_r == '0);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.popped_value  = out_popped_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.entry_count   = out_count_r;
  assign out_ch.total         = out_agg_r.total;
  assign out_ch.largest       = out_agg_r.largest;
  assign out_ch.smallest_even = out_agg_r.smallest_even;
  assign out_ch.is_empty      = out_empty_r;

  `BDQA_ASSERT(a_occ_matches_cells, (state_r == S_IDLE) |-> occ_cells_ok, "occupancy vs cells")
  `BDQA_ASSERT(a_push_grows, push_ok |=> (occ_r == $past(occ_r) + CNT_W'(1)), "push did not grow")
  `BDQA_ASSERT(a_accept_starts_scan, in_acc |=> (state_r == S_SCAN) && (step_r == '0), "no scan")

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// Bounded deque with aggregates testbench
// Sends push, pop and status operations through the input channel and checks
// every result against a shadow deque kept in the testbench. Empty and full
// corners, every opcode and extreme values come first. Random segments
// follow that lean toward pushing, popping or neither, with random idling on
// both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS       = bdqa_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_OPS  = 400;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic        [bdqa_pkg::OP_W-1:0]    op;
    logic signed [bdqa_pkg::VALUE_W-1:0] value;
    bit                                  wait_idle;
  } deque_op_t;

  typedef struct {
    logic signed [bdqa_pkg::VALUE_W-1:0]  popped_value;
    logic        [bdqa_pkg::STATUS_W-1:0] status;
    logic        [bdqa_pkg::COUNT_W-1:0]  entry_count;
    logic signed [bdqa_pkg::TOTAL_W-1:0]  total;
    logic signed [bdqa_pkg::VALUE_W-1:0]  largest;
    logic signed [bdqa_pkg::VALUE_W-1:0]  smallest_even;
    logic                                 is_empty;
  } deque_result_t;

  logic clk;
  logic rst_n;

  bdqa_in_if  in_ch ();
  bdqa_out_if out_ch ();

  bounded_deque_with_aggregates_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [bdqa_pkg::VALUE_W-1:0] shadow_cells [SLOTS];
  int                                  shadow_fill;

  deque_op_t     ops_to_send[$];
  deque_result_t deque_results_due[$];

  int fail_count;
  int cycle_count;
  int send_gap;
  int send_calm;
  int accept_hold;
  int accept_calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic deque_result_t apply_deque_op(
      logic [bdqa_pkg::OP_W-1:0] op, logic signed [bdqa_pkg::VALUE_W-1:0] value);
    deque_result_t                       r;
    logic signed [bdqa_pkg::TOTAL_W-1:0] sum;
    logic signed [bdqa_pkg::VALUE_W-1:0] top;
    logic signed [bdqa_pkg::VALUE_W-1:0] low_even;
    logic                                have_even;
    r.popped_value = '0;
    r.status       = bdqa_pkg::ST_OK;
    sum            = '0;
    top            = '0;
    low_even       = -1;
    have_even      = 1'b0;
    if (op == bdqa_pkg::OP_PUSH_FRONT || op == bdqa_pkg::OP_PUSH_BACK) begin
      if (shadow_fill >= SLOTS) begin
        r.status = bdqa_pkg::ST_FULL;
      end else if (op == bdqa_pkg::OP_PUSH_FRONT) begin
        for (int i = SLOTS - 1; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[0] = value;
        shadow_fill++;
      end else begin
        shadow_cells[shadow_fill] = value;
        shadow_fill++;
      end
    end else if (op == bdqa_pkg::OP_POP_FRONT || op == bdqa_pkg::OP_POP_BACK) begin
      if (shadow_fill == 0) begin
        r.status = bdqa_pkg::ST_EMPTY;
      end else if (op == bdqa_pkg::OP_POP_FRONT) begin
        r.popped_value = shadow_cells[0];
        for (int i = 0; i < SLOTS - 1; i++) shadow_cells[i] = shadow_cells[i+1];
        shadow_fill--;
      end else begin
        shadow_fill--;
        r.popped_value = shadow_cells[shadow_fill];
      end
    end
    for (int i = 0; i < shadow_fill; i++) begin
      sum += shadow_cells[i];
      if (i == 0 || shadow_cells[i] > top) top = shadow_cells[i];
      if (!shadow_cells[i][0] && (!have_even || shadow_cells[i] < low_even)) begin
        low_even  = shadow_cells[i];
        have_even = 1'b1;
      end
    end
    r.entry_count   = bdqa_pkg::COUNT_W'(shadow_fill);
    r.total         = sum;
    r.largest       = top;
    r.smallest_even = low_even;
    r.is_empty      = (shadow_fill == 0);
    return r;
  endfunction

  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [bdqa_pkg::VALUE_W-1:0] pick_value(bit extremes_only);
    int r;
    r = $urandom_range(0, 9);
    if (extremes_only) begin
      return r[0] ? {1'b0, {(bdqa_pkg::VALUE_W-1){1'b1}}}
                  : {1'b1, {(bdqa_pkg::VALUE_W-1){1'b0}}};
    end
    case (r)
      0: return {1'b0, {(bdqa_pkg::VALUE_W-1){1'b1}}};
      1: return {1'b1, {(bdqa_pkg::VALUE_W-1){1'b0}}};
      2: return $signed($urandom_range(0, 16)) - 8;
      3: return $signed($urandom() & ~32'd1);
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [bdqa_pkg::OP_W-1:0] pick_op(int push_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      return $urandom_range(0, 1) ? bdqa_pkg::OP_PUSH_FRONT : bdqa_pkg::OP_PUSH_BACK;
    end
    if (r < push_pct + pop_pct) begin
      return $urandom_range(0, 1) ? bdqa_pkg::OP_POP_FRONT : bdqa_pkg::OP_POP_BACK;
    end
    return bdqa_pkg::OP_W'(bdqa_pkg::OP_STATUS + $urandom_range(0, 3));
  endfunction

  task automatic queue_op(logic [bdqa_pkg::OP_W-1:0] op,
                          logic signed [bdqa_pkg::VALUE_W-1:0] value, bit wait_idle);
    deque_op_t t;
    t.op        = op;
    t.value     = value;
    t.wait_idle = wait_idle;
    ops_to_send.push_back(t);
  endtask

  task automatic check_field(string name, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // drive operations; hold each one until accepted
  always @(posedge clk) begin
    deque_op_t nxt;
    logic      present;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      present = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        deque_results_due.push_back(apply_deque_op(in_ch.op, in_ch.value));
        present = 1'b0;
      end
      if (!present) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (ops_to_send.size() > 0 &&
                     !(ops_to_send[0].wait_idle && deque_results_due.size() > 0)) begin
          nxt = ops_to_send.pop_front();
          in_ch.op    <= nxt.op;
          in_ch.value <= nxt.value;
          present     = 1'b1;
          send_gap    <= pick_gap(send_calm);
        end
        in_ch.valid <= present;
      end
    end
  end

  // check results; stall the result channel at random
  always @(posedge clk) begin
    deque_result_t want;
    int            gap;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      accept_hold  <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (deque_results_due.size() == 0) begin
          $error("result transaction with no operation pending");
          fail_count++;
        end else begin
          want = deque_results_due.pop_front();
          check_field("popped_value", want.popped_value, out_ch.popped_value);
          check_field("status", want.status, out_ch.status);
          check_field("entry_count", want.entry_count, out_ch.entry_count);
          check_field("total", want.total, out_ch.total);
          check_field("largest", want.largest, out_ch.largest);
          check_field("smallest_even", want.smallest_even, out_ch.smallest_even);
          check_field("is_empty", want.is_empty, out_ch.is_empty);
        end
      end
      if (accept_hold > 0) begin
        accept_hold  <= accept_hold - 1;
        out_ch.ready <= 1'b0;
      end else begin
        gap = pick_gap(accept_calm);
        accept_hold  <= gap;
        out_ch.ready <= (gap == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** bounded_deque_with_aggregates_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int kind;
    int len;
    int sent;
    int push_pct;
    int pop_pct;
    logic signed [bdqa_pkg::VALUE_W-1:0] corner_values [SLOTS];

    in_ch.valid  = 1'b0;
    in_ch.op     = bdqa_pkg::OP_STATUS;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    fail_count   = 0;
    cycle_count  = 0;
    send_calm    = 0;
    accept_calm  = 0;
    shadow_fill  = 0;
    foreach (shadow_cells[i]) shadow_cells[i] = '0;

    corner_values = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1,
                      32'sd1, -32'sd2, 32'sd2, 32'sh7FFFFFFE,
                      32'sh80000001, 32'sh55555555, 32'shAAAAAAAA, -32'sd4,
                      32'sd100, 32'sh7FFFFFFF, 32'sh80000000, 32'sd6};

    // empty store corners and every status-only code
    queue_op(bdqa_pkg::OP_POP_FRONT, 32'sh12345678, 1'b0);
    queue_op(bdqa_pkg::OP_POP_BACK, -32'sd1, 1'b0);
    for (int k = 0; k < 4; k++) begin
      queue_op(bdqa_pkg::OP_W'(bdqa_pkg::OP_STATUS + k), $signed($urandom()), 1'b0);
    end
    // fill to capacity from both ends, then push on full
    for (int k = 0; k < SLOTS; k++) begin
      queue_op(k[0] ? bdqa_pkg::OP_PUSH_BACK : bdqa_pkg::OP_PUSH_FRONT, corner_values[k],
               1'b0);
    end
    queue_op(bdqa_pkg::OP_PUSH_FRONT, 32'sd8, 1'b0);
    queue_op(bdqa_pkg::OP_PUSH_BACK, 32'sd9, 1'b0);

    // the first random operation, and about one in a hundred after it, waits until the store has reported everything
    sent = 0;
    while (sent < RANDOM_OPS) begin
      kind = $urandom_range(0, 3);
      len  = $urandom_range(20, 50);
      case (kind)
        0, 3:    begin push_pct = 70; pop_pct = 22; end
        1:       begin push_pct = 22; pop_pct = 70; end
        default: begin push_pct = 42; pop_pct = 42; end
      endcase
      for (int k = 0; k < len && sent < RANDOM_OPS; k++) begin
        queue_op(pick_op(push_pct, pop_pct), pick_value(kind == 3),
                 sent == 0 || $urandom_range(0, 99) == 0);
        sent++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_to_send.size() > 0 || in_ch.valid) @(posedge clk);
    while (deque_results_due.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (fail_count == 0 && deque_results_due.size() == 0) begin
      $display("** bounded_deque_with_aggregates_core: PASSED **");
    end else begin
      $display("** bounded_deque_with_aggregates_core: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/bdqa_pkg.sv
design/bdqa_if.sv
design/bdqa_cell.sv
design/bdqa_accum.sv
design/bounded_deque_with_aggregates_core.sv
tb/tb_top.sv
